// ===== src/linear_probe_hash_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// linear probe hash table - assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// widths, codes and shared types of the linear probe hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W         = 31;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int IDX_W         = 10;
  localparam int SIZE_W        = 11;
  localparam int SIZE_RESET    = 1024;
  localparam int MAX_SLOTS_DEF = 1024;

  // remainder unit: bits retired per cycle
  localparam int MOD_BITS   = 4;
  localparam int KEY_PAD    = ((KEY_W + MOD_BITS - 1) / MOD_BITS) * MOD_BITS;
  localparam int MOD_ROUNDS = KEY_PAD / MOD_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  typedef struct packed {
    mark_t            mark;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== src/lpht_mod.sv =====
// ----------------------------------------------------------------------------
// lpht_mod
// key modulo table size, restoring remainder, MOD_BITS quotient bits a cycle
// ----------------------------------------------------------------------------
module lpht_mod (
  input  logic             clk,
  input  logic             rst_n,
  input  lpht_pkg::mod_req_t req,
  output lpht_pkg::mod_rsp_t rsp
);
  import lpht_pkg::*;

  localparam int CW = (MOD_ROUNDS > 1) ? $clog2(MOD_ROUNDS) : 1;

  logic [KEY_PAD-1:0] dvd_r;
  logic [SIZE_W-1:0]  div_r;
  logic [SIZE_W-1:0]  rem_r;
  logic [SIZE_W-1:0]  rem_nxt;
  logic [CW-1:0]      cnt_r;
  logic               run_r;
  logic               done_r;

  // remainder stays below the divisor, so each trial fits one extra bit
  always_comb begin
    logic [SIZE_W:0] trial;
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_BITS; i++) begin
      trial = {rem_nxt, dvd_r[KEY_PAD-1-i]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !run_r) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(MOD_ROUNDS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !run_r) begin
      dvd_r <= KEY_PAD'(req.dividend);
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= dvd_r << MOD_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// open addressing hash table with linear probing over one slot memory
// ----------------------------------------------------------------------------
//  channel  | ports                                   | transaction
//  ---------+-----------------------------------------+---------------------------
//  command  | start, busy, in_opcode, in_key          | start high while busy low
//  result   | out_valid, out_status, out_found,       | out_valid high, one cycle,
//           | out_slot_index                          | cannot be held off
//  config   | cfg_we, cfg_wdata                       | cfg_we high, any cycle
//
// an operation hashes the key in the remainder unit, then probes p slots,
// p = slots probed (1 .. table size), one slot read a cycle, and shows the
// result in the cycle that busy goes low
// an unused opcode answers in the next cycle and leaves busy low
// after reset a clearing pass marks every slot empty, busy high
// results are never held off; busy alone covers the whole operation
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_unit_defines.svh"

module linear_probe_hash_table_unit #(
  parameter int unsigned MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lpht_pkg::OP_W-1:0]  in_opcode,
  input  logic [lpht_pkg::KEY_W-1:0] in_key,
  output logic                       out_valid,
  output logic [lpht_pkg::ST_W-1:0]  out_status,
  output logic                       out_found,
  output logic [lpht_pkg::IDX_W-1:0] out_slot_index,
  input  logic                       cfg_we,
  input  logic [lpht_pkg::SIZE_W-1:0] cfg_wdata
);
  import lpht_pkg::*;

  localparam int AW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SIZE_MAX = (1 << SIZE_W) - 1;
  localparam int CAP      = (MAX_SLOTS > SIZE_MAX) ? SIZE_MAX : MAX_SLOTS;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAP);

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] cfg_size_r;
  logic [SIZE_W-1:0] n_eff;
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] pos_r, pos_nxt;
  logic [SIZE_W-1:0] steps_r, steps_nxt;
  logic [AW-1:0]     clr_r;
  logic              op_ok;

  entry_t            mem [MAX_SLOTS];
  entry_t            rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [AW-1:0]     mem_raddr;

  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  logic              probe_last;
  logic              probe_stop;
  logic              probe_hit;
  logic              probe_we;
  status_t           probe_status;
  entry_t            probe_wdata;

  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic              out_found_r, out_found_nxt;
  logic [IDX_W-1:0]  out_slot_r, out_slot_nxt;

  assign op_ok = (in_opcode == OP_INSERT) || (in_opcode == OP_REMOVE) ||
                 (in_opcode == OP_SEARCH);

  // zero acts as one, oversize clamps to the slot count
  always_comb begin
    if (cfg_size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (cfg_size_r > SIZE_CAP) begin
      n_eff = SIZE_CAP;
    end else begin
      n_eff = cfg_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= SIZE_W'(SIZE_RESET);
    end else if (cfg_we) begin
      cfg_size_r <= cfg_wdata;
    end
  end

  assign mod_req.start    = (state_r == S_IDLE) && start && op_ok;
  assign mod_req.dividend = in_key;
  assign mod_req.divisor  = n_eff;

  lpht_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // one probe a cycle: rd_data_r holds the slot at pos_r
  assign probe_last = (steps_r == n_eff - SIZE_W'(1));
  assign pos_nxt    = (pos_r == n_eff - SIZE_W'(1)) ? '0 : pos_r + SIZE_W'(1);
  assign steps_nxt  = steps_r + SIZE_W'(1);

  always_comb begin
    probe_stop   = 1'b0;
    probe_hit    = 1'b0;
    probe_we     = 1'b0;
    probe_status = ST_ABSENT;
    probe_wdata  = rd_data_r;
    case (op_r)
      OP_INSERT: begin
        if (rd_data_r.mark != MARK_USED) begin
          probe_stop        = 1'b1;
          probe_hit         = 1'b1;
          probe_we          = 1'b1;
          probe_status      = ST_DONE;
          probe_wdata.mark  = MARK_USED;
          probe_wdata.key   = key_r;
        end else if (probe_last) begin
          probe_stop   = 1'b1;
          probe_status = ST_FULL;
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (rd_data_r.mark == MARK_EMPTY) begin
          probe_stop = 1'b1;
        end else if (rd_data_r.mark == MARK_USED && rd_data_r.key == key_r) begin
          probe_stop       = 1'b1;
          probe_hit        = 1'b1;
          probe_status     = ST_DONE;
          probe_we         = (op_r == OP_REMOVE);
          probe_wdata.mark = MARK_DELETED;
        end else if (probe_last) begin
          probe_stop = 1'b1;
        end
      end
      default: begin
        probe_stop = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && op_ok) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_rsp.done) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_stop) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs and memory control
  always_comb begin
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = '{mark: MARK_EMPTY, key: '0};
    mem_raddr      = AW'(pos_nxt);
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (start && !op_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ABSENT;
          out_found_nxt  = 1'b0;
          out_slot_nxt   = '0;
        end
      end
      S_HASH: begin
        mem_raddr = AW'(mod_rsp.rem);
      end
      S_PROBE: begin
        mem_we    = probe_we;
        mem_waddr = AW'(pos_r);
        mem_wdata = probe_wdata;
        if (probe_stop) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = probe_status;
          out_found_nxt  = probe_hit;
          out_slot_nxt   = probe_hit ? pos_r[IDX_W-1:0] : '0;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
    if (mod_req.start) begin
      op_r  <= in_opcode;
      key_r <= in_key;
    end
    if (state_r == S_HASH) begin
      pos_r   <= mod_rsp.rem;
      steps_r <= '0;
    end else if (state_r == S_PROBE) begin
      pos_r   <= pos_nxt;
      steps_r <= steps_nxt;
    end
  end

  // slot memory; an operation writes at most one slot, and that write lands long
  // before the next transaction's first read, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_slot_index = out_slot_r;

  `LPHT_ASSERT_NEXT(a_stop_result, state_r == S_PROBE && probe_stop, out_valid, "no result")
  `LPHT_ASSERT_NEXT(a_accept_busy, start && !busy && op_ok, busy, "busy low after accept")
  `LPHT_ASSERT_NOW(a_found_status, out_valid, out_found == (out_status == ST_DONE), "found vs status")
  `LPHT_ASSERT_NOW(a_miss_slot, out_valid && !out_found, out_slot_index == '0, "slot on a miss")
  `LPHT_ASSERT_NOW(a_probe_bound, state_r == S_PROBE, steps_r < n_eff && pos_r < n_eff, "probe overrun")

endmodule

// ===== test/lpht_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpht_result_checker
// watches the command, result and config channels of the hash table, keeps
// its own copy of the slot marks, keys and table size, works out the reply to
// every accepted command and compares each reply field by field in order
// ----------------------------------------------------------------------------
module lpht_result_checker #(
  parameter int unsigned SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [lpht_pkg::OP_W-1:0]   in_opcode,
  input  logic [lpht_pkg::KEY_W-1:0]  in_key,
  input  logic                        out_valid,
  input  logic [lpht_pkg::ST_W-1:0]   out_status,
  input  logic                        out_found,
  input  logic [lpht_pkg::IDX_W-1:0]  out_slot_index,
  input  logic                        cfg_we,
  input  logic [lpht_pkg::SIZE_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  import lpht_pkg::*;

  typedef struct packed {
    status_t          status;
    logic             found;
    logic [IDX_W-1:0] slot;
  } reply_t;

  mark_t             slot_mark [SLOTS];
  logic [KEY_W-1:0]  slot_key  [SLOTS];
  logic [SIZE_W-1:0] size_reg = SIZE_W'(SIZE_RESET);
  reply_t            replies_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // zero acts as one, anything past the memory acts as the memory
  function automatic int unsigned live_slots();
    int unsigned n;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic reply_t probe_table(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key);
    int unsigned n;
    int unsigned pos;
    reply_t      r;
    n   = live_slots();
    pos = key % n;
    r   = '{ST_ABSENT, 1'b0, '0};
    if (op == OP_INSERT) begin
      r.status = ST_FULL;
      for (int unsigned s = 0; s < n; s++) begin
        if (slot_mark[pos] != MARK_USED) begin
          slot_key[pos]  = key;
          slot_mark[pos] = MARK_USED;
          r = '{ST_DONE, 1'b1, pos[IDX_W-1:0]};
          break;
        end
        pos = (pos + 1 == n) ? 0 : pos + 1;
      end
    end else if (op == OP_REMOVE || op == OP_SEARCH) begin
      // deleted slots are passed over, an empty one ends the search
      for (int unsigned s = 0; s < n; s++) begin
        if (slot_mark[pos] == MARK_EMPTY) break;
        if (slot_mark[pos] == MARK_USED && slot_key[pos] == key) begin
          if (op == OP_REMOVE) slot_mark[pos] = MARK_DELETED;
          r = '{ST_DONE, 1'b1, pos[IDX_W-1:0]};
          break;
        end
        pos = (pos + 1 == n) ? 0 : pos + 1;
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_mark[i] = MARK_EMPTY;
        slot_key[i]  = '0;
      end
      size_reg = SIZE_W'(SIZE_RESET);
      replies_due.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      // push before pop so a same-edge reply still matches the oldest
      if (start && !busy) replies_due.push_back(probe_table(in_opcode, in_key));
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          log_mismatch($sformatf("unexpected reply status %0d found %0b slot %0d",
                                 out_status, out_found, out_slot_index));
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status)
            log_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_found !== want.found)
            log_mismatch($sformatf("found got %0b want %0b", out_found, want.found));
          if (out_slot_index !== want.slot)
            log_mismatch($sformatf("slot got %0d want %0d", out_slot_index, want.slot));
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

// ===== test/tb_linear_probe_hash_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_unit
// drives insert, remove and search commands through a range of table sizes,
// first a directed run over collisions, wrap, full table, deleted slots and
// size limits, then random phases of mostly well-formed key traffic with
// varying sender gaps; a checker beside the block predicts every reply
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_unit;
  import lpht_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int              N_PHASES  = 15;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_opcode = '0;
  logic [KEY_W-1:0]   in_key    = '0;
  logic               out_valid;
  logic [ST_W-1:0]    out_status;
  logic               out_found;
  logic [IDX_W-1:0]   out_slot_index;
  logic               cfg_we    = 1'b0;
  logic [SIZE_W-1:0]  cfg_wdata = '0;
  int                 fail_count;
  int                 pending;

  int unsigned        idle_pct  = 0;
  int unsigned        cur_size  = SIZE_RESET;
  logic [KEY_W-1:0]   recent_keys [$];

  int unsigned phase_size  [N_PHASES] = '{1, 5, 16, 3, 1024, 0, 8, 37, 2, 1025,
                                          64, 11, 2047, 256, 7};
  int unsigned phase_items [N_PHASES] = '{110, 110, 110, 110, 40, 110, 110, 110,
                                          110, 40, 110, 110, 40, 40, 110};

  always #1 clk = ~clk;

  linear_probe_hash_table_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_slot_index (out_slot_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  lpht_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_slot_index (out_slot_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // called at a falling edge; returns at a falling edge with start still high
  // unless a gap was taken
  task automatic issue_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    in_opcode <= op;
    in_key    <= key;
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  endtask

  task automatic wait_until_idle();
    start <= 1'b0;
    while (pending != 0 || busy !== 1'b0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic program_table_size(input int unsigned value);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= SIZE_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_size  = (value == 0) ? 1 : (value > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : value;
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(3))
      0:       k = KEY_W'($urandom);
      1:       k = KEY_W'($urandom_range(0, 63));
      // same home slot as other keys, to force collisions
      2:       k = KEY_W'($urandom_range(0, 3) + cur_size * $urandom_range(0, 2000000));
      default: k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 15));
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    if (recent_keys.size() == 0) return fresh_key();
    return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
  endfunction

  task automatic run_random_phase(input int unsigned count);
    int unsigned      pick;
    logic [KEY_W-1:0] k;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        k = fresh_key();
        recent_keys.push_back(k);
        if (recent_keys.size() > 64) void'(recent_keys.pop_front());
        issue_command(OP_INSERT, k);
      end else if (pick < 40) begin
        issue_command(OP_INSERT, known_key());
      end else if (pick < 65) begin
        issue_command(OP_SEARCH, known_key());
      end else if (pick < 85) begin
        issue_command(OP_REMOVE, known_key());
      end else if (pick < 93) begin
        issue_command($urandom_range(1) ? OP_SEARCH : OP_REMOVE, fresh_key());
      end else if (pick < 97) begin
        issue_command(OP_UNUSED, KEY_W'($urandom));
      end else begin
        issue_command(OP_W'($urandom_range(0, 3)), KEY_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // clearing pass keeps busy high
    wait_until_idle();

    // four slots: collisions, wrap, full table, deleted slots
    program_table_size(4);
    issue_command(OP_INSERT, 31'd0);
    issue_command(OP_INSERT, 31'd4);
    issue_command(OP_INSERT, 31'h7FFF_FFFF);
    issue_command(OP_INSERT, 31'd7);
    issue_command(OP_INSERT, 31'd8);
    issue_command(OP_SEARCH, 31'd4);
    issue_command(OP_SEARCH, 31'd12);
    issue_command(OP_REMOVE, 31'd0);
    issue_command(OP_SEARCH, 31'd4);
    issue_command(OP_REMOVE, 31'd0);
    issue_command(OP_INSERT, 31'd4);
    issue_command(OP_UNUSED, 31'h2AAA_AAAA);
    issue_command(OP_SEARCH, 31'h7FFF_FFFF);
    // zero behaves as a single slot
    program_table_size(0);
    issue_command(OP_SEARCH, 31'd5);
    issue_command(OP_REMOVE, 31'd4);
    issue_command(OP_INSERT, 31'h5555_5555);
    // register maximum clamps to the full memory; old slots stay as they are
    program_table_size(2047);
    issue_command(OP_SEARCH, 31'd7);
    issue_command(OP_INSERT, 31'd1023);
    issue_command(OP_INSERT, 31'd2047);
    issue_command(OP_SEARCH, 31'd2047);
    issue_command(OP_REMOVE, 31'd1023);
    issue_command(OP_SEARCH, 31'd3071);
    issue_command(OP_INSERT, 31'd1023);

    for (int p = 0; p < N_PHASES; p++) begin
      program_table_size(phase_size[p]);
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 69;
        default: idle_pct = 23;
      endcase
      run_random_phase(phase_items[p]);
    end

    wait_until_idle();
    repeat (64) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
